[src/ssds_pkg.sv]
// Shared types, codes and the segment font for the display serialiser.
`default_nettype none

package ssds_pkg;

    // Command codes carried on op
    typedef enum logic [1:0] {
        OP_CHAR   = 2'd0,
        OP_BRIGHT = 2'd1,
        OP_LED    = 2'd2,
        OP_RAW    = 2'd3
    } op_t;

    // One decoded frame: two bytes and the display line to select
    typedef struct packed {
        logic [7:0] address;
        logic [7:0] data;
        logic       line;
    } frame_t;

    // Serialiser sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_START = 3'd1,
        S_BIT   = 3'd2,
        S_ACK   = 3'd3,
        S_STOP  = 3'd4
    } back_state_t;

    localparam logic [7:0] DIGIT_BASE_ADDR = 8'h68;
    localparam logic [7:0] BRIGHT_ADDR     = 8'h48;
    localparam logic [7:0] LED_ADDR        = 8'h6E;
    localparam logic [7:0] DOT_BIT         = 8'h80;
    localparam logic [7:0] FONT_FIRST      = 8'd48;
    localparam logic [7:0] FONT_LAST       = 8'd91;
    localparam logic [7:0] PERIOD_CHAR     = 8'd46;
    localparam int         FONT_SIZE       = 44;

    localparam logic [7:0] FONT [FONT_SIZE] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74, 8'h30, 8'h1E,
        8'h70, 8'h38, 8'h37, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h2D, 8'h78,
        8'h3E, 8'h1C, 8'h14, 8'h76, 8'h6E, 8'h1B, 8'h40
    };

endpackage

`default_nettype wire

[src/ssds_front.sv]
// Command decoder: turns a display command into an address byte, a data byte and a line.
`default_nettype none

module ssds_front
    import ssds_pkg::*;
(
    input  wire logic [1:0] op,
    input  wire logic       display_select,
    input  wire logic [1:0] position,
    input  wire logic [7:0] char_code,
    input  wire logic       dot,
    input  wire logic [7:0] level,
    input  wire logic [7:0] raw_address,
    input  wire logic [7:0] raw_data,
    output frame_t          frame
);

    logic [5:0] font_offset;
    logic       in_font;
    logic [7:0] segments;
    logic       dot_on;

    assign font_offset = 6'(char_code - FONT_FIRST);
    assign in_font     = (char_code >= FONT_FIRST) && (char_code <= FONT_LAST);

    always_comb
    begin
        segments = in_font ? FONT[font_offset] : 8'h00;
        // a period shows blank with the point lit
        dot_on   = dot || (char_code == PERIOD_CHAR);
        if (char_code == PERIOD_CHAR)
        begin
            segments = 8'h00;
        end

        frame.line = display_select;
        case (op_t'(op))
            OP_CHAR:
            begin
                frame.address = DIGIT_BASE_ADDR + {5'd0, position, 1'b0};
                frame.data    = segments | (dot_on ? DOT_BIT : 8'h00);
            end
            OP_BRIGHT:
            begin
                frame.address = BRIGHT_ADDR;
                frame.data    = (level == 8'd0) ? 8'h00 : {1'b0, level[2:0], 4'b0001};
            end
            OP_LED:
            begin
                frame.address = LED_ADDR;
                frame.data    = raw_data;
                frame.line    = 1'b1;
            end
            default:
            begin
                frame.address = raw_address;
                frame.data    = raw_data;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/ssds_queue.sv]
// Small frame queue between the decoder and the serialiser.
`default_nettype none

module ssds_queue
    import ssds_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  frame_t      push_frame,
    output logic        full,
    input  wire logic   pop,
    output logic        not_empty,
    output frame_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_only_when_filled: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> not_empty)
        else $error("queue empty after a push");

endmodule

`default_nettype wire

[src/ssds_back.sv]
// Line sequencer: plays a queued frame out as clock and data line steps.
`default_nettype none

module ssds_back
    import ssds_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    input  frame_t      q_frame,
    output logic        q_pop,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic        clock_level,
    output logic        data_level,
    output logic        line_select,
    output logic        last_step
);

    back_state_t  state_reg, state_next;
    logic [1:0]   sub_reg, sub_next;
    logic [2:0]   bit_reg, bit_next;
    logic         byte_reg, byte_next;
    logic [15:0]  shift_reg, shift_next;
    logic         line_reg, line_next;
    logic         clk_reg, clk_next;
    logic         dat_reg, dat_next;
    logic         valid_reg, valid_next;
    logic         last_reg, last_next;
    logic         advance;

    // the output register may take a new step when empty or being drained
    assign advance     = !valid_reg || !out_stall;
    assign out_valid   = valid_reg;
    assign clock_level = clk_reg;
    assign data_level  = dat_reg;
    assign line_select = line_reg;
    assign last_step   = last_reg;

    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        line_next  = line_reg;
        clk_next   = clk_reg;
        dat_next   = dat_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (advance)
        begin
            valid_next = 1'b1;
            last_next  = 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        // first start step: data high, clock holds its level
                        q_pop      = 1'b1;
                        shift_next = {q_frame.address, q_frame.data};
                        line_next  = q_frame.line;
                        dat_next   = 1'b1;
                        state_next = S_START;
                        sub_next   = 2'd1;
                    end
                    else
                    begin
                        valid_next = 1'b0;
                    end
                end
                S_START:
                begin
                    case (sub_reg)
                        2'd1:
                        begin
                            clk_next = 1'b1;
                            sub_next = 2'd2;
                        end
                        2'd2:
                        begin
                            dat_next = 1'b0;
                            sub_next = 2'd3;
                        end
                        default:
                        begin
                            clk_next   = 1'b0;
                            state_next = S_BIT;
                            sub_next   = 2'd0;
                            bit_next   = 3'd0;
                            byte_next  = 1'b0;
                        end
                    endcase
                end
                S_BIT:
                begin
                    case (sub_reg)
                        2'd0:
                        begin
                            dat_next = shift_reg[15];
                            sub_next = 2'd1;
                        end
                        2'd1:
                        begin
                            clk_next = 1'b1;
                            sub_next = 2'd2;
                        end
                        default:
                        begin
                            clk_next   = 1'b0;
                            shift_next = {shift_reg[14:0], 1'b0};
                            sub_next   = 2'd0;
                            if (bit_reg == 3'd7)
                            begin
                                state_next = S_ACK;
                            end
                            else
                            begin
                                bit_next = bit_reg + 3'd1;
                            end
                        end
                    endcase
                end
                S_ACK:
                begin
                    // dummy acknowledge clock; data keeps the last bit
                    if (sub_reg == 2'd0)
                    begin
                        clk_next = 1'b1;
                        sub_next = 2'd1;
                    end
                    else
                    begin
                        clk_next = 1'b0;
                        sub_next = 2'd0;
                        if (!byte_reg)
                        begin
                            byte_next  = 1'b1;
                            bit_next   = 3'd0;
                            state_next = S_BIT;
                        end
                        else
                        begin
                            state_next = S_STOP;
                        end
                    end
                end
                S_STOP:
                begin
                    case (sub_reg)
                        2'd0:
                        begin
                            dat_next = 1'b0;
                            sub_next = 2'd1;
                        end
                        2'd1:
                        begin
                            clk_next = 1'b1;
                            sub_next = 2'd2;
                        end
                        default:
                        begin
                            dat_next   = 1'b1;
                            last_next  = 1'b1;
                            sub_next   = 2'd0;
                            state_next = S_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    valid_next = 1'b0;
                    state_next = S_IDLE;
                    sub_next   = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sub_reg   <= 2'd0;
            bit_reg   <= 3'd0;
            byte_reg  <= 1'b0;
            line_reg  <= 1'b0;
            clk_reg   <= 1'b0;
            dat_reg   <= 1'b1;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            line_reg  <= line_next;
            clk_reg   <= clk_next;
            dat_reg   <= dat_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    a_stop_release: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && last_reg |-> clk_reg && dat_reg && (state_reg == S_IDLE))
        else $error("last step is not a stop release");

    a_frame_opens: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> valid_reg && dat_reg && !last_reg && (state_reg == S_START))
        else $error("frame did not open with data high");

    a_one_line_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (clk_reg != $past(clk_reg)) |-> (dat_reg == $past(dat_reg)))
        else $error("clock and data changed in the same step");

    a_data_steady_clock_high: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIT || state_reg == S_ACK) && $past(clk_reg) && clk_reg
            |-> $stable(dat_reg))
        else $error("data moved while clock high inside a byte");

endmodule

`default_nettype wire

[src/seven_segment_display_serializer_unit.sv]
// A command is queued first; the sequencer registers its first step once it is free.
// A frame is 59 line steps, one per cycle from the sequencer unless the output stalls.
// A queue of QUEUE_DEPTH frames lets commands be taken while a frame is being played out.
// Back-to-back frames follow each other with no idle step when the output is not stalled.
// Reset: queue empty, output invalid, clock line low, data line high, top line selected.
`default_nettype none

module seven_segment_display_serializer_unit
    import ssds_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] op,
    input  wire logic       display_select,
    input  wire logic [1:0] position,
    input  wire logic [7:0] char_code,
    input  wire logic       dot,
    input  wire logic [7:0] level,
    input  wire logic [7:0] raw_address,
    input  wire logic [7:0] raw_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            clock_level,
    output logic            data_level,
    output logic            line_select,
    output logic            last_step
);

    frame_t decoded;
    frame_t head;
    logic   full;
    logic   not_empty;
    logic   pop;

    assign in_stall = full;

    ssds_front u_front (
        .op             (op),
        .display_select (display_select),
        .position       (position),
        .char_code      (char_code),
        .dot            (dot),
        .level          (level),
        .raw_address    (raw_address),
        .raw_data       (raw_data),
        .frame          (decoded)
    );

    ssds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_frame (decoded),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    ssds_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (not_empty),
        .q_frame     (head),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .clock_level (clock_level),
        .data_level  (data_level),
        .line_select (line_select),
        .last_step   (last_step)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the seven-segment display serialiser.
module tb
    import ssds_pkg::*;
();

    typedef struct {
        op_t        op;
        logic       sel;
        logic [1:0] pos;
        logic [7:0] ch;
        logic       dot;
        logic [7:0] lvl;
        logic [7:0] raddr;
        logic [7:0] rdata;
    } display_cmd_t;

    typedef struct packed {
        logic clk_l;
        logic data_l;
        logic line_l;
        logic last_l;
    } line_step_t;

    localparam logic [7:0] ADDR_DIGIT0  = 8'h68;
    localparam logic [7:0] ADDR_BRIGHT  = 8'h48;
    localparam logic [7:0] ADDR_LED     = 8'h6E;
    localparam logic [7:0] SEG_DOT      = 8'h80;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_PERIOD  = 8'd46;
    localparam logic [7:0] CHAR_FONT_LO = 8'd48;
    localparam logic [7:0] CHAR_FONT_HI = 8'd91;
    localparam int         IDLE_LIMIT   = 5000;
    localparam int         TAIL_CYCLES  = 64;
    localparam int         MAX_REPORTS  = 100;

    localparam logic [7:0] SEG_FONT [44] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74, 8'h30, 8'h1E,
        8'h70, 8'h38, 8'h37, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h2D, 8'h78,
        8'h3E, 8'h1C, 8'h14, 8'h76, 8'h6E, 8'h1B, 8'h40
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] op;
    logic       display_select;
    logic [1:0] position;
    logic [7:0] char_code;
    logic       dot;
    logic [7:0] level;
    logic [7:0] raw_address;
    logic [7:0] raw_data;
    logic       out_valid;
    logic       out_stall;
    logic       clock_level;
    logic       data_level;
    logic       line_select;
    logic       last_step;

    display_cmd_t pending_cmds[$];
    display_cmd_t cur_cmd;
    line_step_t   line_steps_due[$];
    logic         cmd_taken = 1'b0;
    logic         clk_line = 1'b0;   // clock line level carried across frames
    int           cmds_queued = 0;
    int           cmds_taken = 0;
    int           steps_seen = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    seven_segment_display_serializer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .display_select (display_select),
        .position       (position),
        .char_code      (char_code),
        .dot            (dot),
        .level          (level),
        .raw_address    (raw_address),
        .raw_data       (raw_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .clock_level    (clock_level),
        .data_level     (data_level),
        .line_select    (line_select),
        .last_step      (last_step)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    task automatic push_step(input logic c, input logic d, input logic l, input logic t);
        line_step_t s;
        s = {c, d, l, t};
        line_steps_due.push_back(s);
    endtask

    // Work out the two bytes of a command and the 59 line steps of its frame.
    task automatic expand_frame(input display_cmd_t c);
        logic [7:0] addr_b;
        logic [7:0] data_b;
        logic [7:0] byte_b;
        logic       line_b;
        logic       dot_on;
        logic       dl;
        int         b;
        int         i;
        dot_on = c.dot;
        data_b = 8'h00;
        case (c.op)
            OP_CHAR:
            begin
                if (c.ch == CHAR_PERIOD)
                    dot_on = 1'b1;
                else if (c.ch >= CHAR_FONT_LO && c.ch <= CHAR_FONT_HI)
                    data_b = SEG_FONT[6'(c.ch - CHAR_FONT_LO)];
                addr_b = ADDR_DIGIT0 + {5'd0, c.pos, 1'b0};
                data_b = data_b | (dot_on ? SEG_DOT : 8'h00);
                line_b = c.sel;
            end
            OP_BRIGHT:
            begin
                addr_b = ADDR_BRIGHT;
                data_b = (c.lvl == 8'd0) ? 8'h00 : {1'b0, c.lvl[2:0], 4'b0001};
                line_b = c.sel;
            end
            OP_LED:
            begin
                addr_b = ADDR_LED;
                data_b = c.rdata;
                line_b = 1'b1;
            end
            default:
            begin
                addr_b = c.raddr;
                data_b = c.rdata;
                line_b = c.sel;
            end
        endcase

        // start: clock keeps its previous level on the first step
        dl = 1'b1;
        push_step(clk_line, dl, line_b, 1'b0);
        clk_line = 1'b1;
        push_step(clk_line, dl, line_b, 1'b0);
        dl = 1'b0;
        push_step(clk_line, dl, line_b, 1'b0);
        clk_line = 1'b0;
        push_step(clk_line, dl, line_b, 1'b0);

        for (b = 0; b < 2; b++)
        begin
            byte_b = (b == 0) ? addr_b : data_b;
            for (i = 7; i >= 0; i--)
            begin
                dl = byte_b[i];
                push_step(clk_line, dl, line_b, 1'b0);
                clk_line = 1'b1;
                push_step(clk_line, dl, line_b, 1'b0);
                clk_line = 1'b0;
                push_step(clk_line, dl, line_b, 1'b0);
            end
            // dummy acknowledge: data line holds the last bit
            clk_line = 1'b1;
            push_step(clk_line, dl, line_b, 1'b0);
            clk_line = 1'b0;
            push_step(clk_line, dl, line_b, 1'b0);
        end

        dl = 1'b0;
        push_step(clk_line, dl, line_b, 1'b0);
        clk_line = 1'b1;
        push_step(clk_line, dl, line_b, 1'b0);
        dl = 1'b1;
        push_step(clk_line, dl, line_b, 1'b1);
    endtask

    function automatic display_cmd_t make_cmd(input op_t o, input logic s, input logic [1:0] p,
                                              input logic [7:0] c, input logic d,
                                              input logic [7:0] l, input logic [7:0] a,
                                              input logic [7:0] v);
        display_cmd_t r;
        r.op = o;
        r.sel = s;
        r.pos = p;
        r.ch = c;
        r.dot = d;
        r.lvl = l;
        r.raddr = a;
        r.rdata = v;
        return r;
    endfunction

    function automatic display_cmd_t random_cmd();
        display_cmd_t r;
        int           pick;
        r.op = op_t'($urandom_range(3));
        r.sel = 1'($urandom_range(1));
        r.pos = 2'($urandom_range(3));
        r.ch = 8'($urandom_range(255));
        r.dot = 1'($urandom_range(1));
        r.lvl = 8'($urandom_range(255));
        r.raddr = 8'($urandom_range(255));
        r.rdata = 8'($urandom_range(255));
        if (r.op == OP_CHAR)
        begin
            // bias towards the font, with blanks and stray codes mixed in
            pick = $urandom_range(9);
            if (pick < 5)
                r.ch = 8'($urandom_range(CHAR_FONT_HI, CHAR_FONT_LO));
            else if (pick == 5)
                r.ch = CHAR_SPACE;
            else if (pick == 6)
                r.ch = CHAR_PERIOD;
        end
        if (r.op == OP_BRIGHT && $urandom_range(7) == 0)
            r.lvl = 8'd0;
        return r;
    endfunction

    task automatic queue_cmd(input display_cmd_t c);
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    // Run one stretch of random commands, then hold until every frame is out.
    task automatic play_phase(input int idle_pct, input int stall_pct, input int count);
        int k;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < count; k++)
            queue_cmd(random_cmd());
        while (!(cmds_taken == cmds_queued && line_steps_due.size() == 0))
            @(posedge clk);
    endtask

    // Driver: present the next command at the falling edge, hold it while stalled.
    always @(negedge clk)
    begin
        display_cmd_t nxt;
        if (rst_n)
        begin
            if (!in_valid || cmd_taken)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_cmds.pop_front();
                    cur_cmd <= nxt;
                    op <= nxt.op;
                    display_select <= nxt.sel;
                    position <= nxt.pos;
                    char_code <= nxt.ch;
                    dot <= nxt.dot;
                    level <= nxt.lvl;
                    raw_address <= nxt.raddr;
                    raw_data <= nxt.rdata;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predict on each command transfer, check each line step transfer.
    always @(posedge clk)
    begin
        line_step_t want;
        if (rst_n)
        begin
            cmd_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expand_frame(cur_cmd);
                cmds_taken++;
            end
            if (out_valid && !out_stall)
            begin
                if (line_steps_due.size() == 0)
                begin
                    report_mismatch($sformatf("step %0d arrived with no frame pending", steps_seen));
                end
                else
                begin
                    want = line_steps_due.pop_front();
                    if (clock_level !== want.clk_l)
                        report_mismatch($sformatf("step %0d clock_level got %b want %b",
                                                  steps_seen, clock_level, want.clk_l));
                    if (data_level !== want.data_l)
                        report_mismatch($sformatf("step %0d data_level got %b want %b",
                                                  steps_seen, data_level, want.data_l));
                    if (line_select !== want.line_l)
                        report_mismatch($sformatf("step %0d line_select got %b want %b",
                                                  steps_seen, line_select, want.line_l));
                    if (last_step !== want.last_l)
                        report_mismatch($sformatf("step %0d last_step got %b want %b",
                                                  steps_seen, last_step, want.last_l));
                end
                steps_seen++;
            end
        end
    end

    // Watchdog: drop the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_CHAR;
        display_select = 1'b0;
        position = 2'd0;
        char_code = 8'd0;
        dot = 1'b0;
        level = 8'd0;
        raw_address = 8'd0;
        raw_data = 8'd0;
        out_stall = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // characters: font ends, blanks, dot forcing, codes outside the font
        queue_cmd(make_cmd(OP_CHAR, 1'b0, 2'd0, 8'd48, 1'b0, 8'hFF, 8'hFF, 8'hFF));
        queue_cmd(make_cmd(OP_CHAR, 1'b1, 2'd3, CHAR_FONT_HI, 1'b1, 8'h00, 8'h00, 8'h00));
        queue_cmd(make_cmd(OP_CHAR, 1'b0, 2'd1, CHAR_SPACE, 1'b0, 8'h55, 8'hAA, 8'h55));
        queue_cmd(make_cmd(OP_CHAR, 1'b1, 2'd2, CHAR_PERIOD, 1'b0, 8'h00, 8'h00, 8'h00));
        queue_cmd(make_cmd(OP_CHAR, 1'b1, 2'd0, 8'd0, 1'b1, 8'h00, 8'h00, 8'h00));
        queue_cmd(make_cmd(OP_CHAR, 1'b0, 2'd3, 8'd255, 1'b0, 8'hFF, 8'hFF, 8'hFF));
        queue_cmd(make_cmd(OP_CHAR, 1'b0, 2'd2, 8'd47, 1'b1, 8'h00, 8'h00, 8'h00));
        queue_cmd(make_cmd(OP_CHAR, 1'b1, 2'd1, 8'd92, 1'b0, 8'h00, 8'h00, 8'h00));
        queue_cmd(make_cmd(OP_CHAR, 1'b0, 2'd1, 8'd65, 1'b1, 8'h00, 8'h00, 8'h00));
        // brightness: off, lowest, zero low bits, all ones
        queue_cmd(make_cmd(OP_BRIGHT, 1'b0, 2'd3, 8'hFF, 1'b1, 8'd0, 8'hFF, 8'hFF));
        queue_cmd(make_cmd(OP_BRIGHT, 1'b1, 2'd0, 8'h00, 1'b0, 8'd1, 8'h00, 8'h00));
        queue_cmd(make_cmd(OP_BRIGHT, 1'b0, 2'd0, 8'h00, 1'b0, 8'd8, 8'h00, 8'h00));
        queue_cmd(make_cmd(OP_BRIGHT, 1'b1, 2'd2, 8'h30, 1'b0, 8'd255, 8'h12, 8'h34));
        // LED byte: line forced to the bottom display whatever the select
        queue_cmd(make_cmd(OP_LED, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00, 8'hA5));
        queue_cmd(make_cmd(OP_LED, 1'b1, 2'd3, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'h00));
        queue_cmd(make_cmd(OP_LED, 1'b0, 2'd1, 8'h00, 1'b0, 8'h00, 8'h00, 8'hFF));
        // raw writes
        queue_cmd(make_cmd(OP_RAW, 1'b0, 2'd0, 8'hFF, 1'b1, 8'hFF, 8'h00, 8'h00));
        queue_cmd(make_cmd(OP_RAW, 1'b1, 2'd3, 8'h00, 1'b0, 8'h00, 8'hFF, 8'hFF));
        queue_cmd(make_cmd(OP_RAW, 1'b1, 2'd2, 8'h00, 1'b0, 8'h00, 8'h5A, 8'hC3));

        play_phase(0, 0, 120);
        play_phase(85, 0, 90);
        play_phase(0, 85, 90);
        play_phase(29, 29, 90);
        play_phase(0, 0, 40);

        // hold a little longer to catch any stray step
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && line_steps_due.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
